### rtl/core/podo_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the odometry integrator.
package podo_pkg;

   localparam int TRIG_BITS_DEF = 16;
   localparam int POS_BITS_DEF  = 48;
   localparam logic [31:0] DT_MAX_US  = 32'd1000000;
   localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIG_POSE,
      ST_MUL,
      ST_ACCUM,
      ST_TRIG_QUAT,
      ST_OUT
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/podo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, quadrant applied at the end.
module podo_cordic #(
   parameter int TRIG_BITS = podo_pkg::TRIG_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            angle,
   output logic                   done,
   output logic signed [TRIG_BITS+1:0] cos_out,
   output logic signed [TRIG_BITS+1:0] sin_out
);
   import podo_pkg::*;

   localparam int VW = TRIG_BITS + 2;
   localparam int IW = $clog2(TRIG_BITS + 1);
   localparam logic [32:0] GAIN_RND =
      ({1'b0, CORDIC_GAIN} + (33'd1 << (31 - TRIG_BITS))) >> (32 - TRIG_BITS);

   logic               busy_ff, busy_in;
   logic [IW-1:0]      iter_ff, iter_in;
   logic [1:0]         quad_ff, quad_in;
   logic signed [VW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic               done_ff, done_in;
   logic signed [VW-1:0] dx, dy;
   logic signed [32:0] at;

   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      at = $signed({1'b0, atan_entry(5'(iter_ff))});
      busy_in = busy_ff;
      iter_in = iter_ff;
      quad_in = quad_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         quad_in = angle[31:30];
         x_in = VW'(GAIN_RND);
         y_in = '0;
         z_in = $signed({3'b000, angle[29:0]});
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IW'(TRIG_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      quad_ff <= quad_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done = done_ff;

   always_comb begin
      unique case (quad_ff)
         2'd0: begin cos_out = x_ff;  sin_out = y_ff;  end
         2'd1: begin cos_out = -y_ff; sin_out = x_ff;  end
         2'd2: begin cos_out = -x_ff; sin_out = -y_ff; end
         default: begin cos_out = y_ff; sin_out = -x_ff; end
      endcase
   end

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("cordic done longer than one cycle");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic busy after done");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("cordic did not start");

endmodule

### rtl/core/planar_odometry_integrator.sv
// Top level of the planar odometry integrator: handshake, control sequencer and datapath.
//
// Usage: present an item on the req_ channel (timestamp, vel_x, vel_y, yaw_rate); one
// result (pos_x, pos_y, heading, quat_z, quat_w) follows on the rsp_ channel for each
// transfer. The first item after reset has dt = 0 and leaves the pose unchanged.
// Each item goes through two CORDIC passes (old heading, then half the new heading),
// a bit-serial multiply by dt (20 bits, one bit per cycle) of the two rotated velocity
// sums and the yaw rate, an accumulate step and an output step; the next input is
// taken only once the sequencer has returned to idle.
// req_ready is high only while the sequencer is idle.
// The result register holds until rsp_ready; a second item may be taken and computed
// meanwhile, and it then waits in the output state until the register is free.
// Reset clears the pose, heading and stamp history and empties the result register.
module planar_odometry_integrator #(
   parameter int TRIG_BITS = podo_pkg::TRIG_BITS_DEF,
   parameter int POS_BITS  = podo_pkg::POS_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_timestamp,
   input  logic signed [15:0]         req_vel_x,
   input  logic signed [15:0]         req_vel_y,
   input  logic signed [19:0]         req_yaw_rate,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [POS_BITS-1:0] rsp_pos_x,
   output logic signed [POS_BITS-1:0] rsp_pos_y,
   output logic [31:0]                rsp_heading,
   output logic signed [15:0]         rsp_quat_z,
   output logic signed [15:0]         rsp_quat_w
);
   import podo_pkg::*;

   localparam int VW = TRIG_BITS + 2;
   localparam int PW = VW + 17;          // product of trig and velocity
   localparam int SW = PW + 1;           // sum of two products
   localparam int MW = SW + 21;          // times dt (dt < 2^20)
   localparam int EW = (MW > POS_BITS ? MW : POS_BITS) + 2;
   localparam int DTW = 20;
   localparam int CW = $clog2(DTW + 1);
   localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
   localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

   state_type state_ff, state_in;

   logic [31:0]          prev_ff, prev_in;
   logic                 seen_ff, seen_in;
   logic [31:0]          head_ff, head_in;
   logic signed [POS_BITS-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic signed [15:0]   vx_ff, vx_in, vy_ff, vy_in;
   logic signed [19:0]   wz_ff, wz_in;
   logic [DTW-1:0]       dt_ff, dt_in;   // shifts out one bit per cycle in the multiply state
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [SW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [MW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [31:0]          mh_ff, mh_in;
   logic                 ovld_ff, ovld_in;
   logic signed [POS_BITS-1:0] opx_ff, opx_in, opy_ff, opy_in;
   logic [31:0]          oh_ff, oh_in;
   logic signed [15:0]   oz_ff, oz_in, ow_ff, ow_in;

   logic                 c_start;
   logic [31:0]          c_angle;
   logic                 c_done;
   logic signed [VW-1:0] c_cos, c_sin;
   logic                 take;
   logic [31:0]          dlt;
   logic signed [EW-1:0] rx, ry, nx, ny;

   podo_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
      .clock, .reset, .start(c_start), .angle(c_angle),
      .done(c_done), .cos_out(c_cos), .sin_out(c_sin)
   );

   assign take = req_valid && req_ready;
   assign dlt  = req_timestamp - prev_ff;

   function automatic logic signed [15:0] to_q15(input logic signed [VW-1:0] v);
      logic signed [VW+16:0] r;
      if (TRIG_BITS > 15)
         r = (VW+17)'((v + (VW'(1) <<< (TRIG_BITS - 16))) >>> (TRIG_BITS - 15));
      else
         r = (VW+17)'(v) <<< (15 - TRIG_BITS);
      if (r > 32767) return 16'sd32767;
      if (r < -32768) return -16'sd32768;
      return r[15:0];
   endfunction

   always_comb begin
      unique case (state_ff)
         ST_IDLE:      state_in = take ? ST_TRIG_POSE : ST_IDLE;
         ST_TRIG_POSE: state_in = c_done ? ST_MUL : ST_TRIG_POSE;
         ST_MUL:       state_in = (cnt_ff == CW'(DTW - 1)) ? ST_ACCUM : ST_MUL;
         ST_ACCUM:     state_in = ST_TRIG_QUAT;
         ST_TRIG_QUAT: state_in = c_done ? ST_OUT : ST_TRIG_QUAT;
         ST_OUT:       state_in = (!ovld_ff || rsp_ready) ? ST_IDLE : ST_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      c_start = (state_ff == ST_IDLE && take) || (state_ff == ST_ACCUM);
      // the quaternion pass takes half of the heading being written this cycle
      c_angle = (state_ff == ST_ACCUM) ? {head_in[31], head_in[31:1]} : head_ff;
   end

   always_comb begin
      prev_in = prev_ff; seen_in = seen_ff; head_in = head_ff;
      accx_in = accx_ff; accy_in = accy_ff;
      vx_in = vx_ff; vy_in = vy_ff; wz_in = wz_ff; dt_in = dt_ff; cnt_in = cnt_ff;
      sx_in = sx_ff; sy_in = sy_ff; mx_in = mx_ff; my_in = my_ff; mh_in = mh_ff;
      ovld_in = ovld_ff; opx_in = opx_ff; opy_in = opy_ff; oh_in = oh_ff;
      oz_in = oz_ff; ow_in = ow_ff;
      rx = '0; ry = '0; nx = '0; ny = '0;
      if (ovld_ff && rsp_ready) ovld_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            prev_in = req_timestamp;
            seen_in = 1'b1;
            dt_in = !seen_ff ? '0 : (dlt > DT_MAX_US ? DT_MAX_US[DTW-1:0] : dlt[DTW-1:0]);
            vx_in = req_vel_x; vy_in = req_vel_y; wz_in = req_yaw_rate;
         end
         ST_TRIG_POSE: if (c_done) begin
            // four small products, one multiplier's worth each, then serial dt
            sx_in = SW'(vx_ff * c_cos) - SW'(vy_ff * c_sin);
            sy_in = SW'(vx_ff * c_sin) + SW'(vy_ff * c_cos);
            mx_in = '0; my_in = '0; mh_in = '0; cnt_in = '0;
         end
         ST_MUL: begin
            // accumulate MSB first: shift, add on a set dt bit
            mx_in = (mx_ff <<< 1) + (dt_ff[DTW-1] ? MW'(sx_ff) : '0);
            my_in = (my_ff <<< 1) + (dt_ff[DTW-1] ? MW'(sy_ff) : '0);
            mh_in = (mh_ff << 1) + (dt_ff[DTW-1] ? 32'(wz_ff) : 32'd0);
            dt_in = dt_ff << 1;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_ACCUM: begin
            rx = EW'((mx_ff + (MW'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS);
            ry = EW'((my_ff + (MW'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS);
            nx = EW'(accx_ff) + rx;
            ny = EW'(accy_ff) + ry;
            accx_in = nx > EW'(PMAX) ? PMAX : (nx < EW'(PMIN) ? PMIN : nx[POS_BITS-1:0]);
            accy_in = ny > EW'(PMAX) ? PMAX : (ny < EW'(PMIN) ? PMIN : ny[POS_BITS-1:0]);
            head_in = head_ff + mh_ff;
         end
         ST_TRIG_QUAT: ;
         ST_OUT: if (!ovld_ff || rsp_ready) begin
            // load the result register only once it is free; the CORDIC outputs hold
            ovld_in = 1'b1;
            opx_in = accx_ff; opy_in = accy_ff; oh_in = head_ff;
            oz_in = to_q15(c_sin); ow_in = to_q15(c_cos);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff <= '0; seen_ff <= 1'b0; head_ff <= '0;
         accx_ff <= '0; accy_ff <= '0; ovld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_ff <= prev_in; seen_ff <= seen_in; head_ff <= head_in;
         accx_ff <= accx_in; accy_ff <= accy_in; ovld_ff <= ovld_in;
      end
      vx_ff <= vx_in; vy_ff <= vy_in; wz_ff <= wz_in; dt_ff <= dt_in; cnt_ff <= cnt_in;
      sx_ff <= sx_in; sy_ff <= sy_in; mx_ff <= mx_in; my_ff <= my_in; mh_ff <= mh_in;
      opx_ff <= opx_in; opy_ff <= opy_in; oh_ff <= oh_in; oz_ff <= oz_in; ow_ff <= ow_in;
   end

   assign rsp_valid = ovld_ff;
   assign rsp_pos_x = opx_ff;
   assign rsp_pos_y = opy_ff;
   assign rsp_heading = oh_ff;
   assign rsp_quat_z = oz_ff;
   assign rsp_quat_w = ow_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff == ST_TRIG_POSE) else $error("transfer not started");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_heading) && $stable(rsp_quat_z) && $stable(rsp_quat_w))
      else $error("result changed while waiting");
   a_seen_after: assert property (@(posedge clock) disable iff (reset)
      take |=> seen_ff) else $error("stamp not recorded");

endmodule
